### hw/rtl/multiset_fisher_yates_shuffle_macros.svh
// assertion helpers for the shuffle block
// each expects clk_i and rst_ni in the scope where it is used
`ifndef MULTISET_FISHER_YATES_SHUFFLE_MACROS_SVH
`define MULTISET_FISHER_YATES_SHUFFLE_MACROS_SVH

// consequent in the same cycle
`define FYS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fys check failed");

// consequent in the next cycle
`define FYS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fys check failed");

// consequent in a later cycle, as the macro body gives it
`define FYS_ASSERT_AFTER2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error("fys check failed");

`endif

### hw/rtl/fys_pkg.sv
`default_nettype none

package fys_pkg;

  // field and register widths
  localparam int PCT_W     = 7;
  localparam int LEN_W     = 7;
  localparam int RIDX_W    = 6;
  localparam int POS_W     = 6;
  localparam int SYM_W     = 2;
  localparam int NUM_CLASS = 4;

  // count arithmetic: floor(x / 100) as (x * 5243) >> 19, exact for x below 2**14
  localparam int PROD_W      = 2 * PCT_W;
  localparam int RECIP_W     = 13;
  localparam int QUOT_W      = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT = 19;
  localparam int CNT_W       = QUOT_W - RECIP_SHIFT;
  localparam int BASE_W      = CNT_W + 2;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  // count sequencer runs over the classes plus a final drain step
  localparam int CALC_W = 3;
  localparam logic [CALC_W-1:0] CALC_LAST = 3'd4;

  // register reset values
  localparam logic [PCT_W-1:0] RST_SEQ_LENGTH = 7'd64;
  localparam logic [PCT_W-1:0] RST_PCT_H      = 7'd50;
  localparam logic [PCT_W-1:0] RST_PCT_P      = 7'd30;
  localparam logic [PCT_W-1:0] RST_PCT_BASIC  = 7'd10;
  localparam logic [PCT_W-1:0] RST_PCT_ACIDIC = 7'd10;

  // register indexes (byte address bits 4:2)
  typedef enum logic [2:0] {
    REG_SEQ_LENGTH = 3'd0,
    REG_PCT_H      = 3'd1,
    REG_PCT_P      = 3'd2,
    REG_PCT_BASIC  = 3'd3,
    REG_PCT_ACIDIC = 3'd4
  } fys_reg_e;

  // symbol classes
  typedef enum logic [SYM_W-1:0] {
    SYM_H     = 2'd0,
    SYM_P     = 2'd1,
    SYM_PLUS  = 2'd2,
    SYM_MINUS = 2'd3
  } fys_sym_e;

  // controller to datapath commands
  typedef struct packed {
    logic              calc_mul;
    logic              calc_div;
    logic [CALC_W-1:0] calc_idx;
    logic              fill;
    logic              load;
    logic              step;
  } fys_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/multiset_fisher_yates_shuffle.sv
// channel    signals                                      direction
// request    start, busy, rand_index_i                    in, busy out
// result     done_o, position_o, symbol_o, last_o,        out
//            range_error_o
// config     psel, penable, pwrite, paddr, pwdata,        in, prdata and
//            prdata, pready                               pready out
//
// a request accepted in the idle state moves the block to the step state, and
// the result is then registered onto done_o, unless a known register is written along with it
// the block is busy in the step state and takes no new request there; the position
// table takes one write per request and the next request reads what that write left
// after reset and after every write to a known register the block stays busy
// while the shared multiplier derives the four class counts
// results are shown for one cycle only; the receiver cannot stall them
`default_nettype none

module multiset_fisher_yates_shuffle import fys_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [RIDX_W-1:0] rand_index_i,
  output logic                   done_o,
  output logic [POS_W-1:0]       position_o,
  output logic [SYM_W-1:0]       symbol_o,
  output logic                   last_o,
  output logic                   range_error_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int LEN_CAP   = (MAX_LEN < 127) ? MAX_LEN : 127;
  localparam int TAB_DEPTH = (MAX_LEN < 128) ? MAX_LEN : 128;
  localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);

  // configuration registers
  logic [PCT_W-1:0] seq_length_q, pct_h_q, pct_p_q, pct_basic_q, pct_acidic_q;
  logic             cfg_we, restart;
  fys_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = fys_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_length_q <= RST_SEQ_LENGTH;
      pct_h_q      <= RST_PCT_H;
      pct_p_q      <= RST_PCT_P;
      pct_basic_q  <= RST_PCT_BASIC;
      pct_acidic_q <= RST_PCT_ACIDIC;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_SEQ_LENGTH: seq_length_q <= pwdata[PCT_W-1:0];
        REG_PCT_H:      pct_h_q      <= pwdata[PCT_W-1:0];
        REG_PCT_P:      pct_p_q      <= pwdata[PCT_W-1:0];
        REG_PCT_BASIC:  pct_basic_q  <= pwdata[PCT_W-1:0];
        REG_PCT_ACIDIC: pct_acidic_q <= pwdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // writes to a known register restart the shuffle
  always_comb begin
    case (reg_sel)
      REG_SEQ_LENGTH, REG_PCT_H, REG_PCT_P, REG_PCT_BASIC, REG_PCT_ACIDIC:
        restart = cfg_we;
      default: restart = 1'b0;
    endcase
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_SEQ_LENGTH: prdata = 32'(seq_length_q);
      REG_PCT_H:      prdata = 32'(pct_h_q);
      REG_PCT_P:      prdata = 32'(pct_p_q);
      REG_PCT_BASIC:  prdata = 32'(pct_basic_q);
      REG_PCT_ACIDIC: prdata = 32'(pct_acidic_q);
      default:        prdata = '0;
    endcase
  end

  // effective length: zero acts as one, capped at MAX_LEN and never above 127
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    if (seq_length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (seq_length_q > LEN_CAP_V) begin
      eff_len = LEN_CAP_V;
    end else begin
      eff_len = seq_length_q;
    end
  end

  logic [NUM_CLASS-1:0][PCT_W-1:0] pct;
  assign pct = {pct_acidic_q, pct_basic_q, pct_p_q, pct_h_q};

  fys_cmd_t cmd;

  fys_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .restart_i (restart),
    .busy_o    (busy),
    .cmd_o     (cmd)
  );

  fys_dp #(
    .TAB_DEPTH (TAB_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .len_i         (eff_len),
    .pct_i         (pct),
    .rand_index_i  (rand_index_i),
    .done_o        (done_o),
    .position_o    (position_o),
    .symbol_o      (symbol_o),
    .last_o        (last_o),
    .range_error_o (range_error_o)
  );

endmodule

`default_nettype wire

### hw/rtl/fys_ctrl.sv
`default_nettype none

module fys_ctrl import fys_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic restart_i,
  output logic      busy_o,
  output fys_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_FILL = 4'b0100,
    ST_STEP = 4'b1000
  } fys_state_e;

  fys_state_e        state_q, state_d;
  logic [CALC_W-1:0] cnt_q, cnt_d;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      ST_CALC: begin
        cnt_d = cnt_q + CALC_W'(1);
        if (cnt_q == CALC_LAST) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: state_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: state_d = ST_IDLE;
      default: state_d = ST_CALC;
    endcase
    // a write to a known register recomputes the counts from scratch
    if (restart_i) begin
      state_d = ST_CALC;
      cnt_d   = '0;
    end
  end

  // state registers, counts are derived right after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CALC;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // commands
  assign busy_o         = (state_q != ST_IDLE);
  assign cmd_o.calc_mul = (state_q == ST_CALC) && (cnt_q != CALC_LAST);
  assign cmd_o.calc_div = (state_q == ST_CALC) && (cnt_q != '0);
  assign cmd_o.calc_idx = cnt_q;
  assign cmd_o.fill     = (state_q == ST_FILL);
  assign cmd_o.load     = (state_q == ST_IDLE) && start_i;
  assign cmd_o.step     = (state_q == ST_STEP);

endmodule

`default_nettype wire

### hw/rtl/fys_dp.sv
`default_nettype none

module fys_dp import fys_pkg::*; #(
  parameter int TAB_DEPTH = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fys_cmd_t                        cmd_i,
  input  wire logic [LEN_W-1:0]                len_i,
  input  wire logic [NUM_CLASS-1:0][PCT_W-1:0] pct_i,
  input  wire logic [RIDX_W-1:0]               rand_index_i,
  output logic                                 done_o,
  output logic [POS_W-1:0]                     position_o,
  output logic [SYM_W-1:0]                     symbol_o,
  output logic                                 last_o,
  output logic                                 range_error_o
);

  localparam int IDX_W = $clog2(TAB_DEPTH);

  // count computation
  logic [PROD_W-1:0] prod_q;
  logic [QUOT_W-1:0] quot;
  logic [CNT_W-1:0]  counts_q [NUM_CLASS];
  logic [CALC_W-1:0] div_idx;

  assign quot    = QUOT_W'(prod_q) * QUOT_W'(RECIP_100);
  assign div_idx = cmd_i.calc_idx - CALC_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_mul) begin
      prod_q <= PROD_W'(pct_i[cmd_i.calc_idx[1:0]]) * PROD_W'(len_i);
    end
    if (cmd_i.calc_div) begin
      counts_q[div_idx[1:0]] <= quot[QUOT_W-1 -: CNT_W];
    end
  end

  // shortfall spread H P H + H P H - and cumulative class bases
  logic [BASE_W-1:0] sum_all, len_w, short_w, add_h, add_p, add_b;
  logic [BASE_W-1:0] base0_d, base1_d, base2_d;
  logic [BASE_W-1:0] base0_q, base1_q, base2_q;

  always_comb begin
    sum_all = BASE_W'(counts_q[0]) + BASE_W'(counts_q[1])
            + BASE_W'(counts_q[2]) + BASE_W'(counts_q[3]);
    len_w   = BASE_W'(len_i);
    short_w = (len_w > sum_all) ? (len_w - sum_all) : '0;
    add_h   = (short_w + BASE_W'(1)) >> 1;
    add_p   = (short_w + BASE_W'(2)) >> 2;
    add_b   = (short_w + BASE_W'(4)) >> 3;
    base0_d = BASE_W'(counts_q[0]) + add_h;
    base1_d = base0_d + BASE_W'(counts_q[1]) + add_p;
    base2_d = base1_d + BASE_W'(counts_q[2]) + add_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill) begin
      base0_q <= base0_d;
      base1_q <= base1_d;
      base2_q <= base2_d;
    end
  end

  // request capture with clamping against the unfilled count
  logic [LEN_W-1:0] rem_q;
  logic [LEN_W-1:0] r_in, r_clamp, top_in;
  logic [LEN_W-1:0] r_q, top_q;
  logic             err_in, err_q;

  assign r_in    = LEN_W'(rand_index_i);
  assign top_in  = rem_q - LEN_W'(1);
  assign err_in  = (r_in >= rem_q);
  assign r_clamp = err_in ? top_in : r_in;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q   <= r_clamp;
      top_q <= top_in;
      err_q <= err_in;
    end
  end

  // position table with written marks; unmarked entries read their own index
  logic [IDX_W-1:0]     table_q [TAB_DEPTH];
  logic [IDX_W-1:0]     rd_a_q, rd_b_q;
  logic [TAB_DEPTH-1:0] marks_q;
  logic                 mark_a_q, mark_b_q;
  logic [IDX_W-1:0]     pos, top_val;
  logic                 fin;

  assign pos     = mark_a_q ? rd_a_q : r_q[IDX_W-1:0];
  assign top_val = mark_b_q ? rd_b_q : top_q[IDX_W-1:0];
  assign fin     = (rem_q == LEN_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_a_q   <= table_q[r_clamp[IDX_W-1:0]];
      rd_b_q   <= table_q[top_in[IDX_W-1:0]];
      mark_a_q <= marks_q[r_clamp[IDX_W-1:0]];
      mark_b_q <= marks_q[top_in[IDX_W-1:0]];
    end
    if (cmd_i.step) begin
      table_q[r_q[IDX_W-1:0]] <= top_val;
    end
  end

  // marks and unfilled count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
      rem_q   <= '0;
    end else if (cmd_i.fill || (cmd_i.step && fin)) begin
      marks_q <= '0;
      rem_q   <= len_i;
    end else if (cmd_i.step) begin
      marks_q[r_q[IDX_W-1:0]] <= 1'b1;
      rem_q                   <= rem_q - LEN_W'(1);
    end
  end

  // symbol from the index of the top unfilled entry
  fys_sym_e sym;

  always_comb begin
    if (BASE_W'(top_q) < base0_q) begin
      sym = SYM_H;
    end else if (BASE_W'(top_q) < base1_q) begin
      sym = SYM_P;
    end else if (BASE_W'(top_q) < base2_q) begin
      sym = SYM_PLUS;
    end else begin
      sym = SYM_MINUS;
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      position_o    <= POS_W'(pos);
      symbol_o      <= sym;
      last_o        <= fin;
      range_error_o <= err_q;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fys_chk.sv
`default_nettype none

`include "multiset_fisher_yates_shuffle_macros.svh"

module fys_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic done_o
);

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  // an accepted request keeps the block busy in the next cycle
  `FYS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // a request without a concurrent register write is followed by a result on done_o
  `FYS_ASSERT_AFTER2(a_accept_result, start && !busy && !cfg_wr, done_o)

  // results never come in two adjacent cycles
  `FYS_ASSERT_NEXT(a_result_spacing, done_o, !done_o)

  // a result only follows a busy cycle
  `FYS_ASSERT_SAME(a_result_after_busy, done_o, $past(busy))

endmodule

bind multiset_fisher_yates_shuffle fys_chk u_fys_chk (.*);

`default_nettype wire
